// ===== sv/mcbq_pkg.sv =====
// ============================================================================
// mcbq_pkg
// Shared constants for the multichannel cascaded biquad filter.
// ============================================================================
`default_nettype none

package mcbq_pkg;

    // Register indexes on the configuration port.
    localparam int REG_BYPASS      = 0;
    localparam int REG_STAGE_COUNT = 1;
    localparam int REG_COEF_B0     = 2;
    localparam int REG_COEF_B1     = 3;
    localparam int REG_COEF_B2     = 4;
    localparam int REG_COEF_A1     = 5;
    localparam int REG_COEF_A2     = 6;
    localparam int NUM_REGS        = 7;

    // Width of the register index taken from the address.
    localparam int REG_IDX_W = 3;

    // Width of the stage count register.
    localparam int STAGE_REG_W = 3;

    // Stage count every channel is assumed to have used before its first sample.
    localparam int RESET_STAGES = 2;

    // Integer bits of the Q4.x coefficient format.
    localparam int COEF_INT_BITS = 4;

endpackage : mcbq_pkg

`default_nettype wire

// ===== sv/multichannel_cascaded_biquad.sv =====
// ============================================================================
// multichannel_cascaded_biquad
// Per-channel cascade of identical direct-form-1 biquad stages, fixed point.
// ============================================================================
//
// Channel        Dir  Handshake                Payload
// -------------  ---  -----------------------  ---------------------------------
// s_  (samples)  in   s_tvalid / s_tready      s_tuser: channel, s_tdata: sample_in
// m_  (results)  out  m_tvalid / m_tready      m_tdata: sample_out
// APB (config)   in   psel / penable / pready  7 registers, byte address 4*index (8*index when COEF_BITS > 32)
//
// A word that passes through (bypass, zero stages, or a channel number at or
// above CHANNELS) goes from acceptance straight to the output state, which
// loads the output register. A filtered word with N stages first passes the
// check state, which uses the channel's last stage count; then every stage
// passes through the multiply state (the five coefficient multipliers), the
// sum state (the accumulator) and the saturate state (rounding, saturation
// and history write-back), since each stage consumes the previous stage's
// result. The output state then loads the output register. A word whose
// result finds the output register still full waits in the output state
// until m_tready frees it. Reset is synchronous and active low; the
// history needs no clearing pass, as per-entry valid bits make an unwritten
// entry read as zero. One word is in work at a time; a new word is taken while
// a finished result still waits in the output register.
//
// The history of every (channel, stage) pair lives in one RAM entry holding
// x[n-1], x[n-2], y[n-1] and y[n-2]. A second RAM holds the stage count each
// channel last ran with. When the configured count differs from that, the
// channel's valid bits are dropped at once, which clears its history.

`default_nettype none

module multichannel_cascaded_biquad
    import mcbq_pkg::*;
#(
    parameter int CHANNELS    = 32,
    parameter int MAX_STAGES  = 5,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32,
    localparam int CH_W    = (CHANNELS > 32) ? $clog2(CHANNELS) : 5,
    localparam int DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int PDATA_W = (COEF_BITS > 32) ? 64 : 32,
    localparam int ALIGN_W = (COEF_BITS > 32) ? 3 : 2,
    localparam int PADDR_W = REG_IDX_W + ALIGN_W
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [DATA_W-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    input  wire logic [CH_W-1:0]    s_tuser,   // [CH_W-1:0] channel

    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [DATA_W-1:0]  m_tdata,   // [SAMPLE_BITS-1:0] sample_out

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------------
    localparam int HIST_DEPTH = CHANNELS * MAX_STAGES;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HIST_W     = 4 * SAMPLE_BITS;
    localparam int LU_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STAGE_W    = $clog2(MAX_STAGES + 1);
    localparam int CNT_W      = (STAGE_W > STAGE_REG_W) ? STAGE_W : STAGE_REG_W;
    localparam int FRAC       = COEF_BITS - COEF_INT_BITS;
    localparam int PROD_W     = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W      = PROD_W + 3;
    localparam int SH_W       = ACC_W - FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0]   COEF_ONE   = COEF_BITS'(1) << FRAC;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic                          bypass_reg;
    logic [STAGE_REG_W-1:0]        stage_count_reg;
    logic signed [COEF_BITS-1:0]   coef_b0_reg;
    logic signed [COEF_BITS-1:0]   coef_b1_reg;
    logic signed [COEF_BITS-1:0]   coef_b2_reg;
    logic signed [COEF_BITS-1:0]   coef_a1_reg;
    logic signed [COEF_BITS-1:0]   coef_a2_reg;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:ALIGN_W];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg      <= 1'b0;
            stage_count_reg <= STAGE_REG_W'(RESET_STAGES);
            coef_b0_reg     <= COEF_ONE;
            coef_b1_reg     <= '0;
            coef_b2_reg     <= '0;
            coef_a1_reg     <= '0;
            coef_a2_reg     <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_IDX_W'(REG_BYPASS):      bypass_reg      <= pwdata[0];
                REG_IDX_W'(REG_STAGE_COUNT): stage_count_reg <= pwdata[STAGE_REG_W-1:0];
                REG_IDX_W'(REG_COEF_B0):     coef_b0_reg     <= pwdata[COEF_BITS-1:0];
                REG_IDX_W'(REG_COEF_B1):     coef_b1_reg     <= pwdata[COEF_BITS-1:0];
                REG_IDX_W'(REG_COEF_B2):     coef_b2_reg     <= pwdata[COEF_BITS-1:0];
                REG_IDX_W'(REG_COEF_A1):     coef_a1_reg     <= pwdata[COEF_BITS-1:0];
                REG_IDX_W'(REG_COEF_A2):     coef_a2_reg     <= pwdata[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IDX_W'(REG_BYPASS):      prdata = PDATA_W'(bypass_reg);
            REG_IDX_W'(REG_STAGE_COUNT): prdata = PDATA_W'(stage_count_reg);
            REG_IDX_W'(REG_COEF_B0):     prdata = PDATA_W'(coef_b0_reg);
            REG_IDX_W'(REG_COEF_B1):     prdata = PDATA_W'(coef_b1_reg);
            REG_IDX_W'(REG_COEF_B2):     prdata = PDATA_W'(coef_b2_reg);
            REG_IDX_W'(REG_COEF_A1):     prdata = PDATA_W'(coef_a1_reg);
            REG_IDX_W'(REG_COEF_A2):     prdata = PDATA_W'(coef_a2_reg);
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Item acceptance
    // ------------------------------------------------------------------------
    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic                           s_accept;
    logic [CNT_W-1:0]               n_eff;
    logic                           pass_through;
    logic [LU_AW-1:0]               in_ch_idx;
    logic [HIST_AW-1:0]             in_base;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_ch_idx = s_tuser[LU_AW-1:0];
    assign in_base   = HIST_AW'(in_ch_idx) * HIST_AW'(MAX_STAGES);

    // Register values above the stage maximum run the full cascade.
    assign n_eff = (32'(stage_count_reg) > MAX_STAGES) ? CNT_W'(MAX_STAGES)
                                                       : CNT_W'(stage_count_reg);
    assign pass_through = bypass_reg || (n_eff == '0) || (32'(s_tuser) >= CHANNELS);

    // ------------------------------------------------------------------------
    // Per-item working registers
    // ------------------------------------------------------------------------
    logic [LU_AW-1:0]               ch_idx_reg;
    logic [HIST_AW-1:0]             base_reg;
    logic [HIST_AW-1:0]             hist_idx_reg;
    logic [CNT_W-1:0]               n_reg;
    logic [CNT_W-1:0]               stage_reg;
    logic signed [SAMPLE_BITS-1:0]  x_reg;
    logic signed [SAMPLE_BITS-1:0]  res_reg;
    logic signed [SAMPLE_BITS-1:0]  old_x1_reg;
    logic signed [SAMPLE_BITS-1:0]  old_y1_reg;
    logic signed [PROD_W-1:0]       p0_reg;
    logic signed [PROD_W-1:0]       p1_reg;
    logic signed [PROD_W-1:0]       p2_reg;
    logic signed [PROD_W-1:0]       p3_reg;
    logic signed [PROD_W-1:0]       p4_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic [HIST_DEPTH-1:0]          hist_valid_reg;
    logic [HIST_DEPTH-1:0]          hist_valid_next;
    logic [CHANNELS-1:0]            lu_valid_reg;
    logic                           m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]         m_sample_reg;

    // ------------------------------------------------------------------------
    // State memories
    // ------------------------------------------------------------------------
    logic                 hist_we;
    logic [HIST_W-1:0]    hist_wdata;
    logic                 hist_re;
    logic [HIST_AW-1:0]   hist_raddr;
    logic [HIST_W-1:0]    hist_rdata;

    logic                 lu_we;
    logic                 lu_re;
    logic [CNT_W-1:0]     lu_rdata;

    mcbq_ram #(
        .WIDTH (HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (hist_idx_reg),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    mcbq_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CHANNELS)
    ) u_lu_ram (
        .aclk  (aclk),
        .we    (lu_we),
        .waddr (ch_idx_reg),
        .wdata (n_reg),
        .re    (lu_re),
        .raddr (in_ch_idx),
        .rdata (lu_rdata)
    );

    // ------------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0]               lu_cur;
    logic                           lu_mismatch;
    logic                           more_stages;
    logic [HIST_W-1:0]              hist_word;
    logic signed [SAMPLE_BITS-1:0]  h_x1;
    logic signed [SAMPLE_BITS-1:0]  h_x2;
    logic signed [SAMPLE_BITS-1:0]  h_y1;
    logic signed [SAMPLE_BITS-1:0]  h_y2;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [ACC_W-1:0]        acc_rnd;
    logic signed [SH_W-1:0]         acc_sh;
    logic signed [SAMPLE_BITS-1:0]  stage_y;

    // A channel that never stored a count behaves as if it last used the
    // reset count.
    assign lu_cur      = lu_valid_reg[ch_idx_reg] ? lu_rdata : CNT_W'(RESET_STAGES);
    assign lu_mismatch = (lu_cur != n_reg);
    assign more_stages = ((stage_reg + CNT_W'(1)) < n_reg);

    // An entry without its valid bit reads as cleared history.
    assign hist_word = hist_valid_reg[hist_idx_reg] ? hist_rdata : '0;
    assign h_x1 = hist_word[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
    assign h_x2 = hist_word[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign h_y1 = hist_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign h_y2 = hist_word[SAMPLE_BITS-1:0];

    assign acc_next = ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(p2_reg)
                    - ACC_W'(p3_reg) - ACC_W'(p4_reg);

    // Round half up, then an arithmetic shift down to the sample format.
    assign acc_rnd = acc_reg + ROUND_HALF;
    assign acc_sh  = acc_rnd[ACC_W-1:FRAC];

    always_comb begin
        if (!acc_sh[SH_W-1] && (|acc_sh[SH_W-2:SAMPLE_BITS-1])) begin
            stage_y = SAMPLE_MAX;
        end else if (acc_sh[SH_W-1] && !(&acc_sh[SH_W-2:SAMPLE_BITS-1])) begin
            stage_y = SAMPLE_MIN;
        end else begin
            stage_y = acc_sh[SAMPLE_BITS-1:0];
        end
    end

    // Shift the history: new x1 is this stage's input, new y1 its output.
    assign hist_wdata = {x_reg, old_x1_reg, stage_y, old_y1_reg};

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        hist_re    = 1'b0;
        hist_raddr = in_base;
        hist_we    = 1'b0;
        lu_re      = 1'b0;
        lu_we      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // Fetch the count and the first stage's history together.
                    lu_re   = !pass_through;
                    hist_re = !pass_through;
                    state_next = pass_through ? ST_OUT : ST_CHECK;
                end
            end
            ST_CHECK: begin
                lu_we      = lu_mismatch;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // The next stage's history does not depend on this result.
                hist_re    = more_stages;
                hist_raddr = hist_idx_reg + HIST_AW'(1);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = ST_SAT;
            end
            ST_SAT: begin
                hist_we    = 1'b1;
                state_next = more_stages ? ST_MUL : ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        hist_valid_next = hist_valid_reg;
        if ((state_reg == ST_CHECK) && lu_mismatch) begin
            for (int s = 0; s < MAX_STAGES; s++) begin
                hist_valid_next[base_reg + HIST_AW'(s)] = 1'b0;
            end
        end
        if (hist_we) begin
            hist_valid_next[hist_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hist_valid_reg <= '0;
            lu_valid_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hist_valid_reg <= hist_valid_next;
            if (lu_we) begin
                lu_valid_reg[ch_idx_reg] <= 1'b1;
            end
            if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ch_idx_reg   <= in_ch_idx;
            base_reg     <= in_base;
            hist_idx_reg <= in_base;
            n_reg        <= n_eff;
            stage_reg    <= '0;
            x_reg        <= s_tdata[SAMPLE_BITS-1:0];
            res_reg      <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (state_reg == ST_MUL) begin
            p0_reg     <= coef_b0_reg * x_reg;
            p1_reg     <= coef_b1_reg * h_x1;
            p2_reg     <= coef_b2_reg * h_x2;
            p3_reg     <= coef_a1_reg * h_y1;
            p4_reg     <= coef_a2_reg * h_y2;
            old_x1_reg <= h_x1;
            old_y1_reg <= h_y1;
        end
        if (state_reg == ST_SUM) begin
            acc_reg <= acc_next;
        end
        if (state_reg == ST_SAT) begin
            x_reg        <= stage_y;
            res_reg      <= stage_y;
            stage_reg    <= stage_reg + CNT_W'(1);
            hist_idx_reg <= hist_idx_reg + HIST_AW'(1);
        end
        if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready)) begin
            m_sample_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(m_sample_reg);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef SYNTHESIS
    // The stage counter stays inside the cascade while a stage is in work.
    a_stage_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_MUL) || (state_reg == ST_SUM) || (state_reg == ST_SAT))
        |-> (stage_reg < n_reg))
        else $error("stage counter ran past the configured cascade length");

    // A word that enters the filter path has at least one stage to run.
    a_check_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> ((n_reg != '0) && (n_reg <= CNT_W'(MAX_STAGES))))
        else $error("filter path entered with an invalid stage count");

    // After the count check, the channel's stored count matches the cascade.
    a_count_recorded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |=> ((state_reg == ST_MUL) && (stage_reg == '0)
                                     && (lu_valid_reg[ch_idx_reg]
                                         || (n_reg == CNT_W'(RESET_STAGES)))))
        else $error("channel stage count not recorded before filtering");

    // A new result only appears out of the output state.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (!$past(m_tvalid_reg) || $past(m_tready)))
        |-> ($past(state_reg) == ST_OUT))
        else $error("output register loaded outside the output state");
`endif

endmodule : multichannel_cascaded_biquad

`default_nettype wire

// ===== sv/mcbq_ram.sv =====
// ============================================================================
// mcbq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
`default_nettype none

module mcbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : mcbq_ram

`default_nettype wire
